// File: sv/uqad_pkg.sv
// Shared types and constants for the URI query argument decoder.
package uqad_pkg;

   localparam int unsigned MaxLenW      = 13;
   localparam logic [MaxLenW-1:0] MaxLenReset = 13'd256;
   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned ResPerItem   = 3;

   localparam logic [7:0] ChQuery = 8'h3F;
   localparam logic [7:0] ChAmp   = 8'h26;
   localparam logic [7:0] ChPct   = 8'h25;

   typedef enum logic [1:0] {
      PCT_NONE  = 2'd0,
      PCT_SIGN  = 2'd1,
      PCT_DIGIT = 2'd2,
      PCT_SPARE = 2'd3
   } pct_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       field_end;
      logic       in_path;
   } res_type;

   typedef struct packed {
      logic [1:0]                  count;
      res_type [ResPerItem-1:0]    res;
   } bundle_type;

   typedef struct packed {
      logic push;
      logic full;
   } wr_ctl_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } rd_ctl_type;

endpackage

// File: sv/uri_query_arg_decoder.sv
// Top level of the URI query argument decoder.
// Each result beat is written into the bundle queue's registers before it is shown on the rsp_ ports.
// Throughput: one input beat per cycle while the queue is not full; an input beat with k results
// yields k result beats, one per pop, buffered in a four-bundle queue between front end and sequencer.
// Reset: synchronous, clears parse state and queue; max_len returns to 256.
module uri_query_arg_decoder #(
   parameter int unsigned QUEUE_DEPTH = uqad_pkg::QueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_is_end,
   output logic                         empty,
   input  logic                         pop,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_has_byte,
   output logic                         rsp_field_end,
   output logic                         rsp_in_path,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [uqad_pkg::MaxLenW-1:0] csr_max_len
);

   uqad_pkg::wr_ctl_type wr_ctl;
   uqad_pkg::rd_ctl_type rd_ctl;
   uqad_pkg::bundle_type wr_data;
   uqad_pkg::bundle_type head;
   logic                 q_full;
   logic                 q_empty;

   uqad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_in_byte (req_in_byte),
      .req_is_end  (req_is_end),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_max_len (csr_max_len),
      .wr_ctl      (wr_ctl),
      .q_full      (q_full),
      .wr_data     (wr_data)
   );

   uqad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_ctl  (wr_ctl),
      .wr_data (wr_data),
      .full    (q_full),
      .rd_ctl  (rd_ctl),
      .empty   (q_empty),
      .head    (head)
   );

   uqad_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_empty       (q_empty),
      .rd_ctl        (rd_ctl),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_field_end (rsp_field_end),
      .rsp_in_path   (rsp_in_path),
      .rsp_last      (rsp_last)
   );

endmodule

// File: sv/uqad_front.sv
// Front end: accepts URI bytes, tracks parse state and builds result bundles.
module uqad_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_is_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [uqad_pkg::MaxLenW-1:0] csr_max_len,
   output uqad_pkg::wr_ctl_type         wr_ctl,
   input  logic                         q_full,
   output uqad_pkg::bundle_type         wr_data
);

   typedef struct packed {
      uqad_pkg::bundle_type        bd;
      logic [uqad_pkg::MaxLenW-1:0] cnt;
      logic                        drop;
   } acc_type;

   logic [uqad_pkg::MaxLenW-1:0] max_len_ff;
   logic                         arg_phase_ff, arg_phase_in;
   uqad_pkg::pct_type            pct_ff, pct_in;
   logic [7:0]                   held_ff, held_in;
   logic [uqad_pkg::MaxLenW-1:0] count_ff, count_in;
   logic                         drop_ff, drop_in;
   logic [uqad_pkg::MaxLenW-1:0] limit;
   logic                         accept;
   acc_type                      acc;
   logic                         done;
   logic [7:0]                   dec_byte;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic uqad_pkg::bundle_type push_res(input uqad_pkg::bundle_type bd,
                                                     input logic [7:0] b,
                                                     input logic has, input logic fend,
                                                     input logic path);
      uqad_pkg::bundle_type r;
      uqad_pkg::res_type    rs;
      r = bd;
      rs.out_byte  = has ? b : 8'd0;
      rs.has_byte  = has;
      rs.field_end = fend;
      rs.in_path   = path;
      unique case (r.count)
         2'd0: r.res[0] = rs;
         2'd1: r.res[1] = rs;
         2'd2: r.res[2] = rs;
         default: ;
      endcase
      if (r.count != 2'd3) begin
         r.count = r.count + 2'd1;
      end
      return r;
   endfunction

   function automatic acc_type emit_arg(input acc_type a, input logic [7:0] b,
                                        input logic [uqad_pkg::MaxLenW-1:0] lim);
      acc_type r;
      r = a;
      if (!r.drop && r.cnt < lim) begin
         r.bd  = push_res(r.bd, b, 1'b1, 1'b0, 1'b0);
         r.cnt = r.cnt + 1'b1;
      end else begin
         r.drop = 1'b1;
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;
   assign limit     = (max_len_ff == '0) ? '0 : max_len_ff - 1'b1;
   assign dec_byte  = {hex_val(held_ff), hex_val(req_in_byte)};

   always_comb begin
      acc.bd       = '0;
      acc.cnt      = count_ff;
      acc.drop     = drop_ff;
      arg_phase_in = arg_phase_ff;
      pct_in       = pct_ff;
      held_in      = held_ff;
      done         = 1'b0;
      if (req_is_end) begin
         if (arg_phase_ff) begin
            if (!drop_ff) begin
               if (pct_ff == uqad_pkg::PCT_SIGN || pct_ff == uqad_pkg::PCT_DIGIT) begin
                  acc = emit_arg(acc, uqad_pkg::ChPct, limit);
               end
               if (pct_ff == uqad_pkg::PCT_DIGIT) begin
                  acc = emit_arg(acc, held_ff, limit);
               end
            end
            acc.bd = push_res(acc.bd, 8'd0, 1'b0, 1'b1, 1'b0);
         end else begin
            acc.bd = push_res(acc.bd, 8'd0, 1'b0, 1'b1, 1'b1);
         end
         arg_phase_in = 1'b0;
         done         = 1'b1;
      end else if (!arg_phase_ff) begin
         if (req_in_byte == uqad_pkg::ChQuery) begin
            acc.bd       = push_res(acc.bd, 8'd0, 1'b0, 1'b1, 1'b1);
            arg_phase_in = 1'b1;
            done         = 1'b1;
         end else begin
            acc.bd = push_res(acc.bd, req_in_byte, 1'b1, 1'b0, 1'b1);
         end
      end else if (drop_ff) begin
         pct_in = uqad_pkg::PCT_NONE;
         if (req_in_byte == uqad_pkg::ChAmp) begin
            acc.bd = push_res(acc.bd, 8'd0, 1'b0, 1'b1, 1'b0);
            done   = 1'b1;
         end
      end else begin
         if (pct_ff == uqad_pkg::PCT_SIGN) begin
            if (is_hex(req_in_byte)) begin
               held_in = req_in_byte;
               pct_in  = uqad_pkg::PCT_DIGIT;
            end else begin
               acc    = emit_arg(acc, uqad_pkg::ChPct, limit);
               pct_in = uqad_pkg::PCT_NONE;
            end
         end else if (pct_ff == uqad_pkg::PCT_DIGIT) begin
            pct_in = uqad_pkg::PCT_NONE;
            if (is_hex(req_in_byte)) begin
               acc = emit_arg(acc, dec_byte, limit);
            end else begin
               acc = emit_arg(acc, uqad_pkg::ChPct, limit);
               acc = emit_arg(acc, held_ff, limit);
            end
         end else begin
            pct_in = uqad_pkg::PCT_NONE;
         end
         if (!((pct_ff == uqad_pkg::PCT_SIGN || pct_ff == uqad_pkg::PCT_DIGIT) &&
               is_hex(req_in_byte))) begin
            if (req_in_byte == uqad_pkg::ChAmp) begin
               acc.bd = push_res(acc.bd, 8'd0, 1'b0, 1'b1, 1'b0);
               done   = 1'b1;
            end else if (!acc.drop) begin
               if (req_in_byte == uqad_pkg::ChPct) begin
                  pct_in = uqad_pkg::PCT_SIGN;
               end else begin
                  acc = emit_arg(acc, req_in_byte, limit);
               end
            end
         end
      end
      count_in = acc.cnt;
      drop_in  = acc.drop;
      if (done) begin
         pct_in   = uqad_pkg::PCT_NONE;
         held_in  = 8'd0;
         count_in = '0;
         drop_in  = 1'b0;
      end
   end

   assign wr_ctl.push = accept && (acc.bd.count != 2'd0);
   assign wr_ctl.full = q_full;
   assign wr_data     = acc.bd;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= uqad_pkg::MaxLenReset;
         arg_phase_ff <= 1'b0;
         pct_ff       <= uqad_pkg::PCT_NONE;
         held_ff      <= 8'd0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_len_ff <= csr_max_len;
         end
         if (accept) begin
            arg_phase_ff <= arg_phase_in;
            pct_ff       <= pct_in;
            held_ff      <= held_in;
            count_ff     <= count_in;
            drop_ff      <= drop_in;
         end
      end
   end

endmodule

// File: sv/uqad_queue.sv
// Short bundle queue between the front end and the result sequencer.
module uqad_queue #(
   parameter int unsigned DEPTH = uqad_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uqad_pkg::wr_ctl_type wr_ctl,
   input  uqad_pkg::bundle_type wr_data,
   output logic                 full,
   input  uqad_pkg::rd_ctl_type rd_ctl,
   output logic                 empty,
   output uqad_pkg::bundle_type head
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   uqad_pkg::bundle_type  slot_ff [DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  do_wr, do_rd;

   assign full  = (cnt_ff == FullCnt);
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign do_wr = wr_ctl.push && !full;
   assign do_rd = rd_ctl.pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: sv/uqad_back.sv
// Back end: unpacks each queued bundle into single result beats.
module uqad_back (
   input  logic                 clock,
   input  logic                 reset,
   input  uqad_pkg::bundle_type head,
   input  logic                 q_empty,
   output uqad_pkg::rd_ctl_type rd_ctl,
   output logic                 empty,
   input  logic                 pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_has_byte,
   output logic                 rsp_field_end,
   output logic                 rsp_in_path,
   output logic                 rsp_last
);

   logic [1:0]        idx_ff, idx_in;
   uqad_pkg::res_type cur;
   logic              is_last;
   logic              take;

   always_comb begin
      unique case (idx_ff)
         2'd0:    cur = head.res[0];
         2'd1:    cur = head.res[1];
         default: cur = head.res[2];
      endcase
   end

   assign is_last       = (idx_ff == head.count - 2'd1);
   assign take          = pop && !q_empty;
   assign empty         = q_empty;
   assign rd_ctl.pop    = take && is_last;
   assign rd_ctl.empty  = q_empty;
   assign rsp_out_byte  = cur.out_byte;
   assign rsp_has_byte  = cur.has_byte;
   assign rsp_field_end = cur.field_end;
   assign rsp_in_path   = cur.in_path;
   assign rsp_last      = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the URI query argument decoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       fend;
      logic       path;
      logic       tail;
   } res_beat_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic [7:0]                   req_in_byte = 8'h00;
   logic                         req_is_end = 1'b0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic [7:0]                   rsp_out_byte;
   logic                         rsp_has_byte;
   logic                         rsp_field_end;
   logic                         rsp_in_path;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [uqad_pkg::MaxLenW-1:0] csr_max_len = uqad_pkg::MaxLenReset;

   // decoder state as predicted
   logic                         in_query = 1'b0;
   uqad_pkg::pct_type            esc_stage = uqad_pkg::PCT_NONE;
   logic [7:0]                   esc_digit = 8'h00;
   logic [uqad_pkg::MaxLenW-1:0] arg_len = '0;
   logic                         overflowed = 1'b0;
   logic [uqad_pkg::MaxLenW-1:0] max_len_reg = uqad_pkg::MaxLenReset;

   res_beat_type       expected_beats[$];
   res_beat_type       step_beats[$];
   int                 fail_count = 0;
   int                 sent_items = 0;
   int                 send_gap_pct = 12;
   int                 recv_stall_pct = 59;
   int                 hold_cycles = 0;
   int                 idle_cycles = 0;

   uri_query_arg_decoder DUT (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_in_byte   (req_in_byte),
      .req_is_end    (req_is_end),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_has_byte  (rsp_has_byte),
      .rsp_field_end (rsp_field_end),
      .rsp_in_path   (rsp_in_path),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_max_len   (csr_max_len)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] pick_hex();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
      return c;
   endfunction

   task automatic add_beat(input logic [7:0] data, input logic has, input logic fend,
                           input logic path);
      res_beat_type beat;
      beat.data = has ? data : 8'h00;
      beat.has  = has;
      beat.fend = fend;
      beat.path = path;
      beat.tail = 1'b0;
      if (step_beats.size() < uqad_pkg::ResPerItem) step_beats.push_back(beat);
   endtask

   task automatic keep_arg_byte(input logic [7:0] b);
      logic [uqad_pkg::MaxLenW-1:0] cap;
      cap = (max_len_reg == '0) ? '0 : max_len_reg - 1'b1;
      if (!overflowed && arg_len < cap) begin
         add_beat(b, 1'b1, 1'b0, 1'b0);
         arg_len = arg_len + 1'b1;
      end else begin
         overflowed = 1'b1;
      end
   endtask

   task automatic flush_escape();
      if (esc_stage == uqad_pkg::PCT_SIGN) begin
         keep_arg_byte(uqad_pkg::ChPct);
      end else if (esc_stage == uqad_pkg::PCT_DIGIT) begin
         keep_arg_byte(uqad_pkg::ChPct);
         keep_arg_byte(esc_digit);
      end
      esc_stage = uqad_pkg::PCT_NONE;
   endtask

   task automatic clear_arg();
      esc_stage  = uqad_pkg::PCT_NONE;
      esc_digit  = 8'h00;
      arg_len    = '0;
      overflowed = 1'b0;
   endtask

   task automatic predict_decode(input logic [7:0] b, input logic is_end);
      int   nib;
      int   hi;
      logic done;
      step_beats.delete();
      done = 1'b0;
      if (is_end) begin
         if (in_query) begin
            if (!overflowed) flush_escape();
            add_beat(8'h00, 1'b0, 1'b1, 1'b0);
         end else begin
            add_beat(8'h00, 1'b0, 1'b1, 1'b1);
         end
         in_query = 1'b0;
         clear_arg();
      end else if (!in_query) begin
         if (b == uqad_pkg::ChQuery) begin
            add_beat(8'h00, 1'b0, 1'b1, 1'b1);
            in_query = 1'b1;
            clear_arg();
         end else begin
            add_beat(b, 1'b1, 1'b0, 1'b1);
         end
      end else if (overflowed) begin
         esc_stage = uqad_pkg::PCT_NONE;
         if (b == uqad_pkg::ChAmp) begin
            add_beat(8'h00, 1'b0, 1'b1, 1'b0);
            clear_arg();
         end
      end else begin
         nib = hex_nibble(b);
         if (esc_stage == uqad_pkg::PCT_SIGN) begin
            if (nib >= 0) begin
               esc_digit = b;
               esc_stage = uqad_pkg::PCT_DIGIT;
               done = 1'b1;
            end else begin
               flush_escape();
            end
         end else if (esc_stage == uqad_pkg::PCT_DIGIT) begin
            if (nib >= 0) begin
               hi = hex_nibble(esc_digit);
               if (hi < 0) hi = 0;
               esc_stage = uqad_pkg::PCT_NONE;
               keep_arg_byte(8'(hi * 16 + nib));
               done = 1'b1;
            end else begin
               flush_escape();
            end
         end else begin
            esc_stage = uqad_pkg::PCT_NONE;
         end
         if (!done) begin
            if (b == uqad_pkg::ChAmp) begin
               add_beat(8'h00, 1'b0, 1'b1, 1'b0);
               clear_arg();
            end else if (!overflowed) begin
               if (b == uqad_pkg::ChPct) esc_stage = uqad_pkg::PCT_SIGN;
               else keep_arg_byte(b);
            end
         end
      end
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].tail = 1'b1;
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
   endtask

   task automatic send_item(input logic [7:0] b, input logic is_end);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_in_byte <= b;
      req_is_end  <= is_end;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_decode(b, is_end);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic write_max_len(input logic [uqad_pkg::MaxLenW-1:0] v);
      push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid   <= 1'b1;
      csr_max_len <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      max_len_reg = v;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("rsp %s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_beat();
      res_beat_type want;
      if (expected_beats.size() == 0) begin
         $error("rsp beat with nothing expected: out_byte %0h field_end %0b",
                rsp_out_byte, rsp_field_end);
         fail_count++;
      end else begin
         want = expected_beats.pop_front();
         check_field("out_byte", want.data, rsp_out_byte);
         check_field("has_byte", want.has, rsp_has_byte);
         check_field("field_end", want.fend, rsp_field_end);
         check_field("in_path", want.path, rsp_in_path);
         check_field("last", want.tail, rsp_last);
      end
   endtask

   task automatic send_random_arg();
      int n;
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: begin
               send_item(uqad_pkg::ChPct, 1'b0);
               send_item(pick_hex(), 1'b0);
               send_item(pick_hex(), 1'b0);
            end
            1: begin
               send_item(uqad_pkg::ChPct, 1'b0);
               send_item(pick_non_hex(), 1'b0);
            end
            2: begin
               send_item(uqad_pkg::ChPct, 1'b0);
               send_item(pick_hex(), 1'b0);
               send_item(pick_non_hex(), 1'b0);
            end
            3: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: send_item(8'($urandom_range(97, 122)), 1'b0);
         endcase
      end
   endtask

   task automatic send_random_uri();
      int path_len;
      int args;
      path_len = $urandom_range(0, 4);
      for (int i = 0; i < path_len; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 9) < 9) begin
         send_item(uqad_pkg::ChQuery, 1'b0);
         args = $urandom_range(0, 3);
         for (int a = 0; a < args; a++) begin
            send_random_arg();
            if (a < args - 1) send_item(uqad_pkg::ChAmp, 1'b0);
         end
      end
      if ($urandom_range(0, 9) < 8) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         repeat ($urandom_range(1, 3))
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_path_and_escapes();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(uqad_pkg::ChQuery, 1'b0);
      send_text("%41%eF%z%7q&%A");
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      send_text("?%");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_arg_overflow();
      write_max_len(13'd3);
      send_text("?ab%41c&x");
      send_item(8'h5A, 1'b1);
   endtask

   task automatic test_length_extremes();
      write_max_len(13'd0);
      send_text("?a&");
      send_item(8'h00, 1'b1);
      write_max_len(13'd1);
      send_text("?c");
      send_item(8'h00, 1'b1);
      write_max_len(13'd4096);
      send_text("?b");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random(input logic [uqad_pkg::MaxLenW-1:0] len, input int gap_pct,
                              input int stall_pct, input int count);
      int start;
      write_max_len(len);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      start = sent_items;
      while (sent_items - start < count) send_random_uri();
   endtask

   task automatic test_backpressure();
      int start;
      write_max_len(uqad_pkg::MaxLenReset);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      hold_cycles    = 80;
      start = sent_items;
      while (sent_items - start < 20) send_random_uri();
   endtask

   // result side: check accepted beats, then pick pop for the next edge
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_beat();
         if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles--;
         end else begin
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("uri_query_arg_decoder: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_path_and_escapes();
      test_arg_overflow();
      test_length_extremes();
      test_random(13'd4, 12, 59, 45);
      test_random(13'd2, 59, 12, 45);
      test_random(13'd8, 0, 0, 45);
      test_backpressure();
      push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("uri_query_arg_decoder: match");
      end else begin
         $display("uri_query_arg_decoder: mismatch");
      end
      $finish;
   end

endmodule
